// File: rtl/nfir_pkg.sv
// ----------------------------------------------------------------------------
// nfir_pkg
// Shared types and constants for the negated FIR filter.
// ----------------------------------------------------------------------------
package nfir_pkg;

    localparam int OPC_W  = 2;
    localparam int IDX_W  = 7;
    localparam int DATA_W = 16;
    localparam int ACC_W  = 32;
    localparam int TC_W   = 8;
    localparam int SHIFT  = 2;

    localparam logic [TC_W-1:0] TAP_COUNT_RST = 8'd95;
    localparam logic [TC_W-1:0] TAP_MIN       = 8'd2;

    typedef enum logic [OPC_W-1:0] {
        OP_FILTER  = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // MAC step control, aligned with the registered memory read data
    typedef struct packed {
        logic clr;
        logic valid;
        logic last;
    } t_mac_ctl;

endpackage

// File: rtl/nfir_if.sv
// ----------------------------------------------------------------------------
// nfir_in_if / nfir_out_if
// Valid/ready channels carrying input items and filter results.
// ----------------------------------------------------------------------------
interface nfir_in_if import nfir_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic [IDX_W-1:0]         coef_slot;
    logic signed [DATA_W-1:0] coefficient;
    logic signed [DATA_W-1:0] sample_in;

    modport source (output valid, opcode, coef_slot, coefficient, sample_in, input ready);
    modport sink   (input valid, opcode, coef_slot, coefficient, sample_in, output ready);
endinterface

interface nfir_out_if import nfir_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] filtered;

    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

// File: rtl/negated_fir_filter.sv
// ----------------------------------------------------------------------------
// negated_fir_filter
// Negated direct-form FIR filter, programmable tap count, one shared MAC.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        opcode, coef_slot, coefficient, sample_in
//   o_out     out  valid/ready        filtered
//   i_cfg_*   in   write enable only  tap_count (8 bits)
//
// Filter beat: N taps in use; ready stays low from acceptance until the result
// is loaded. The single MAC takes one tap per cycle, then read, multiply and
// accumulate drain. Load, restart and unused beats leave the block ready.
// After reset all MAX_TAPS - 1 history entries are cleared before any beat.
// A finished result waits in the output register; the block stalls only when
// a second result is ready before the first has been taken.
// ----------------------------------------------------------------------------
module negated_fir_filter import nfir_pkg::*; #(
    parameter int  MAX_TAPS = 128,
    localparam int HD       = MAX_TAPS - 1,
    localparam int AW       = $clog2(MAX_TAPS),
    localparam int HAW      = (HD > 1) ? $clog2(HD) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [TC_W-1:0] i_cfg_data,
    nfir_in_if.sink         i_in,
    nfir_out_if.source      o_out
);

    logic                     out_free;
    logic                     out_ld;
    logic                     fin;
    logic                     coef_we;
    logic [AW-1:0]            coef_waddr;
    logic signed [DATA_W-1:0] coef_wdata;
    logic [AW-1:0]            coef_raddr;
    logic signed [DATA_W-1:0] coef_rdata;
    logic                     hist_we;
    logic [HAW-1:0]           hist_waddr;
    logic signed [DATA_W-1:0] hist_wdata;
    logic [HAW-1:0]           hist_raddr;
    logic signed [DATA_W-1:0] hist_rdata;
    t_mac_ctl                 mac_ctl;
    logic signed [DATA_W-1:0] x;
    logic signed [ACC_W-1:0]  acc;
    logic                     r_out_valid;
    logic signed [ACC_W-1:0]  r_filtered;

    assign out_free = !r_out_valid || o_out.ready;

    nfir_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_opcode      (i_in.opcode),
        .i_coef_slot   (i_in.coef_slot),
        .i_coefficient (i_in.coefficient),
        .i_sample_in   (i_in.sample_in),
        .i_out_free    (out_free),
        .o_out_ld      (out_ld),
        .i_fin         (fin),
        .o_coef_we     (coef_we),
        .o_coef_waddr  (coef_waddr),
        .o_coef_wdata  (coef_wdata),
        .o_coef_raddr  (coef_raddr),
        .o_hist_we     (hist_we),
        .o_hist_waddr  (hist_waddr),
        .o_hist_wdata  (hist_wdata),
        .o_hist_raddr  (hist_raddr),
        .o_mac         (mac_ctl),
        .o_x           (x)
    );

    nfir_mem #(.MAX_TAPS(MAX_TAPS)) u_mem (
        .i_clk        (i_clk),
        .i_coef_we    (coef_we),
        .i_coef_waddr (coef_waddr),
        .i_coef_wdata (coef_wdata),
        .i_coef_raddr (coef_raddr),
        .o_coef_rdata (coef_rdata),
        .i_hist_we    (hist_we),
        .i_hist_waddr (hist_waddr),
        .i_hist_wdata (hist_wdata),
        .i_hist_raddr (hist_raddr),
        .o_hist_rdata (hist_rdata)
    );

    nfir_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (coef_rdata),
        .i_hist  (hist_rdata),
        .i_x     (x),
        .o_acc   (acc),
        .o_fin   (fin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_filtered <= acc;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.filtered = r_filtered;

endmodule

// File: rtl/nfir_mem.sv
// ----------------------------------------------------------------------------
// nfir_mem
// Coefficient store and sample history, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module nfir_mem import nfir_pkg::*; #(
    parameter int  MAX_TAPS = 128,
    localparam int HD       = MAX_TAPS - 1,
    localparam int AW       = $clog2(MAX_TAPS),
    localparam int HAW      = (HD > 1) ? $clog2(HD) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_coef_we,
    input  logic [AW-1:0]            i_coef_waddr,
    input  logic signed [DATA_W-1:0] i_coef_wdata,
    input  logic [AW-1:0]            i_coef_raddr,
    output logic signed [DATA_W-1:0] o_coef_rdata,
    input  logic                     i_hist_we,
    input  logic [HAW-1:0]           i_hist_waddr,
    input  logic signed [DATA_W-1:0] i_hist_wdata,
    input  logic [HAW-1:0]           i_hist_raddr,
    output logic signed [DATA_W-1:0] o_hist_rdata
);

    logic signed [DATA_W-1:0] coef_mem [MAX_TAPS];
    logic signed [DATA_W-1:0] hist_mem [HD];
    logic signed [DATA_W-1:0] r_coef_rd;
    logic signed [DATA_W-1:0] r_hist_rd;

    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            coef_mem[i_coef_waddr] <= i_coef_wdata;
        end
        r_coef_rd <= coef_mem[i_coef_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_hist_we) begin
            hist_mem[i_hist_waddr] <= i_hist_wdata;
        end
        r_hist_rd <= hist_mem[i_hist_raddr];
    end

    assign o_coef_rdata = r_coef_rd;
    assign o_hist_rdata = r_hist_rd;

endmodule

// File: rtl/nfir_mac.sv
// ----------------------------------------------------------------------------
// nfir_mac
// Shared multiply-accumulate unit: registered 16x16 product, then the
// accumulator subtracts the product shifted left by two.
// ----------------------------------------------------------------------------
module nfir_mac import nfir_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0] i_hist,
    input  logic signed [DATA_W-1:0] i_x,
    output logic signed [ACC_W-1:0]  o_acc,
    output logic                     o_fin
);

    logic signed [DATA_W-1:0] smp;
    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  r_prod;
    logic                     r_p_valid;
    logic                     r_p_last;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_fin;

    // last step pairs the final coefficient with the new sample
    assign smp  = i_ctl.last ? i_x : i_hist;
    assign prod = i_coef * smp;

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_p_valid) begin
            r_acc <= r_acc - {r_prod[ACC_W-SHIFT-1:0], {SHIFT{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_last  <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            r_p_valid <= i_ctl.valid;
            r_p_last  <= i_ctl.valid & i_ctl.last;
            r_fin     <= r_p_valid & r_p_last;
        end
    end

    assign o_acc = r_acc;
    assign o_fin = r_fin;

endmodule

// File: rtl/nfir_ctrl.sv
// ----------------------------------------------------------------------------
// nfir_ctrl
// Sequencer: history clearing pass, item decode, tap/ring counters and
// memory addressing for the shared MAC.
// ----------------------------------------------------------------------------
module nfir_ctrl import nfir_pkg::*; #(
    parameter int  MAX_TAPS = 128,
    localparam int HD       = MAX_TAPS - 1,
    localparam int AW       = $clog2(MAX_TAPS),
    localparam int HAW      = (HD > 1) ? $clog2(HD) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [TC_W-1:0]          i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OPC_W-1:0]         i_opcode,
    input  logic [IDX_W-1:0]         i_coef_slot,
    input  logic signed [DATA_W-1:0] i_coefficient,
    input  logic signed [DATA_W-1:0] i_sample_in,
    input  logic                     i_out_free,
    output logic                     o_out_ld,
    input  logic                     i_fin,
    output logic                     o_coef_we,
    output logic [AW-1:0]            o_coef_waddr,
    output logic signed [DATA_W-1:0] o_coef_wdata,
    output logic [AW-1:0]            o_coef_raddr,
    output logic                     o_hist_we,
    output logic [HAW-1:0]           o_hist_waddr,
    output logic signed [DATA_W-1:0] o_hist_wdata,
    output logic [HAW-1:0]           o_hist_raddr,
    output t_mac_ctl                 o_mac,
    output logic signed [DATA_W-1:0] o_x
);

    t_state                   r_state, n_state;
    logic [HAW-1:0]           r_clr, n_clr;
    logic [HAW-1:0]           r_ring, n_ring;
    logic [TC_W-1:0]          r_tap_count;
    logic [AW-1:0]            r_len, n_len;
    logic [AW-1:0]            r_t, n_t;
    logic [HAW-1:0]           r_pos, n_pos;
    logic signed [DATA_W-1:0] r_x, n_x;
    t_mac_ctl                 r_s1, n_s1;

    logic                     accept;
    logic                     slot_ok;
    logic [AW-1:0]            len_use;
    logic [HAW-1:0]           pos0;
    logic [AW-1:0]            pos_p1;
    logic [HAW-1:0]           pos_nx;
    logic                     last;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid & o_ready;
    assign slot_ok = (32'(i_coef_slot) < MAX_TAPS);

    always_comb begin
        if (r_tap_count < TAP_MIN) begin
            len_use = AW'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            len_use = AW'(MAX_TAPS - 1);
        end else begin
            len_use = AW'(r_tap_count - 8'd1);
        end
    end

    assign pos0   = (AW'(r_ring) >= len_use) ? '0 : r_ring;
    assign pos_p1 = AW'(r_pos) + AW'(1);
    assign pos_nx = (pos_p1 == r_len) ? '0 : HAW'(pos_p1);
    assign last   = (r_t == r_len);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_ring       = r_ring;
        n_len        = r_len;
        n_t          = r_t;
        n_pos        = r_pos;
        n_x          = r_x;
        n_s1         = '0;
        o_out_ld     = 1'b0;
        o_coef_we    = 1'b0;
        o_hist_we    = 1'b0;
        o_hist_waddr = r_pos;
        o_hist_wdata = r_x;
        unique case (r_state)
            S_CLEAR: begin
                o_hist_we    = 1'b1;
                o_hist_waddr = r_clr;
                o_hist_wdata = '0;
                if (r_clr == HAW'(HD - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + HAW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_FILTER: begin
                            n_len    = len_use;
                            n_pos    = pos0;
                            n_t      = '0;
                            n_x      = i_sample_in;
                            n_s1.clr = 1'b1;
                            n_state  = S_RUN;
                        end
                        OP_LOAD: begin
                            o_coef_we = slot_ok;
                        end
                        OP_RESTART: begin
                            n_ring = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                n_s1.valid = 1'b1;
                n_s1.last  = last;
                if (last) begin
                    // position has wrapped back to the oldest entry
                    o_hist_we = 1'b1;
                    n_ring    = pos_nx;
                    n_state   = S_DRAIN;
                end else begin
                    n_t   = r_t + AW'(1);
                    n_pos = pos_nx;
                end
            end
            S_DRAIN: begin
                if (i_fin) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_ld = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ring      <= '0;
            r_tap_count <= TAP_COUNT_RST;
            r_s1        <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ring  <= n_ring;
            r_s1    <= n_s1;
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_t   <= n_t;
        r_pos <= n_pos;
        r_x   <= n_x;
    end

    assign o_coef_waddr = AW'(i_coef_slot);
    assign o_coef_wdata = i_coefficient;
    assign o_coef_raddr = r_t;
    assign o_hist_raddr = r_pos;
    assign o_mac        = r_s1;
    assign o_x          = r_x;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (AW'(r_pos) < r_len))
        else $error("ring position beyond history length");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_t <= r_len))
        else $error("tap counter overran");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1.valid && !i_fin))
        else $error("MAC activity while idle");

    a_fin_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fin |-> (r_state == S_DRAIN))
        else $error("accumulation finished outside drain");

endmodule

// File: verif/negated_fir_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// negated_fir_filter_tb
// Self-checking bench for the negated FIR filter. A short table of hand-made
// beats runs first, then phases of random loads, restarts, unused opcodes and
// samples over a range of tap counts. A behavioural predictor tracks
// coefficients, history and ring position, and every result beat is checked in order.
// ----------------------------------------------------------------------------
module negated_fir_filter_tb;
    import nfir_pkg::*;

    localparam int MAX_TAPS  = 128;
    localparam int N_PHASES  = 12;
    localparam int CALM_PHASE = 4;
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef enum bit {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [OPC_W-1:0]         op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] coef;
        logic signed [DATA_W-1:0] smp;
        logic [TC_W-1:0]          tc;
        bit                       typed;
        logic signed [ACC_W-1:0]  want;
    } t_row;

    // kind, opcode, slot, coefficient, sample, tap count, typed, result
    localparam t_row DIR_ROWS [23] = '{
        '{ROW_CFG,  OP_FILTER,    0,      0,      0, 0, 0,  0},  // below min, used as 2
        '{ROW_BEAT, OP_LOAD,      0,      0,      0, 0, 0,  0},
        '{ROW_BEAT, OP_LOAD,      1,      0,      0, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,    0,      0,  32767, 0, 1,  0},
        '{ROW_BEAT, OP_LOAD,      1,      1,      0, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,    0,      0,      1, 0, 1, -4},
        '{ROW_BEAT, OP_LOAD,      0,  32767,      0, 0, 0,  0},
        '{ROW_BEAT, OP_LOAD,      1, -32768,      0, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,    0,      0, -32768, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,    0,      0,  32767, 0, 0,  0},
        '{ROW_BEAT, OP_UNUSED,  127,     -1,     -1, 0, 0,  0},
        '{ROW_BEAT, OP_RESTART, 127,     -1,     -1, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,  127,     -1,      0, 0, 0,  0},
        '{ROW_BEAT, OP_LOAD,    127,     -1,  32767, 0, 0,  0},
        '{ROW_CFG,  OP_FILTER,    0,      0,      0, 5, 0,  0},
        '{ROW_BEAT, OP_LOAD,      2,     -1,      0, 0, 0,  0},
        '{ROW_BEAT, OP_LOAD,      3,  12345,      0, 0, 0,  0},
        '{ROW_BEAT, OP_LOAD,      4, -32768,      0, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,    0,      0,  32767, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,    0,      0,     -1, 0, 0,  0},
        '{ROW_BEAT, OP_FILTER,    0,      0,      1, 0, 0,  0},
        '{ROW_CFG,  OP_FILTER,    0,      0,      0, 1, 0,  0},  // ring pos past history
        '{ROW_BEAT, OP_FILTER,    0,      0, -32768, 0, 0,  0}
    };

    localparam logic [TC_W-1:0] PHASE_TAPS [N_PHASES] =
        '{3, 2, 8, 128, 17, 95, 255, 4, 1, 200, 6, 33};
    localparam int PHASE_BEATS [N_PHASES] =
        '{150, 150, 150, 40, 130, 60, 40, 150, 150, 40, 150, 140};

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [TC_W-1:0] i_cfg_data;

    nfir_in_if  in_ch ();
    nfir_out_if out_ch ();

    negated_fir_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [DATA_W-1:0] coef_bank   [MAX_TAPS];
    bit                       coef_known  [MAX_TAPS];
    logic signed [DATA_W-1:0] sample_ring [MAX_TAPS-1];
    int unsigned              ring_head;
    logic [TC_W-1:0]          taps_reg;

    logic signed [ACC_W-1:0] expected_filtered [$];

    bit calm;
    int n_mismatch, n_checked, n_loads, n_restarts, n_ignored, n_cfg;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        n_mismatch++;
    endtask

    function automatic logic [ACC_W-1:0] tap_product(input logic signed [DATA_W-1:0] c,
                                                     input logic signed [DATA_W-1:0] x);
        logic signed [ACC_W-1:0] p;
        p = c * x;
        return p << SHIFT;
    endfunction

    function automatic int unsigned taps_in_use();
        int unsigned n;
        n = taps_reg;
        if (n < 2) n = 2;
        if (n > MAX_TAPS) n = MAX_TAPS;
        return n;
    endfunction

    function automatic logic signed [ACC_W-1:0] filter_sample(
            input logic signed [DATA_W-1:0] x);
        int unsigned len, pos;
        logic [ACC_W-1:0] acc;
        len = taps_in_use() - 1;
        pos = ring_head;
        if (pos >= len) pos = 0;
        acc = '0;
        for (int t = 0; t < len; t++) begin
            acc -= tap_product(coef_bank[t], sample_ring[pos]);
            pos++;
            if (pos >= len) pos = 0;
        end
        acc -= tap_product(coef_bank[len], x);
        sample_ring[pos] = x;
        pos++;
        if (pos >= len) pos = 0;
        ring_head = pos;
        return acc;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        unique case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the beat was taken
    task automatic send_beat(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] coef,
                             input logic signed [DATA_W-1:0] smp,
                             input bit typed, input logic signed [ACC_W-1:0] want);
        logic signed [ACC_W-1:0] res;
        while (!calm && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.coef_slot   <= idx;
        in_ch.coefficient <= coef;
        in_ch.sample_in   <= smp;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        unique case (op)
            OP_LOAD: begin
                coef_bank[idx]  = coef;
                coef_known[idx] = 1'b1;
                n_loads++;
            end
            OP_RESTART: begin
                ring_head = 0;
                n_restarts++;
            end
            OP_FILTER: begin
                res = filter_sample(smp);
                expected_filtered.push_back(typed ? want : res);
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic set_tap_count(input logic [TC_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge i_clk);
        repeat (MAX_TAPS + 8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        taps_reg = v;
        n_cfg++;
    endtask

    always @(posedge i_clk) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_filtered.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", out_ch.filtered));
            end else begin
                if (out_ch.filtered !== expected_filtered[0])
                    report_mismatch($sformatf("filtered %0d, expected %0d",
                                              out_ch.filtered, expected_filtered[0]));
                void'(expected_filtered.pop_front());
                n_checked++;
            end
        end
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_filtered.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned n, cnt, r;
        logic [OPC_W-1:0] op;
        logic [IDX_W-1:0] idx;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = '0;
        in_ch.coef_slot   = '0;
        in_ch.coefficient = '0;
        in_ch.sample_in   = '0;
        calm              = 1'b0;
        taps_reg          = TAP_COUNT_RST;
        ring_head         = 0;
        foreach (coef_bank[i]) begin
            coef_bank[i]  = '0;
            coef_known[i] = 1'b0;
        end
        foreach (sample_ring[i]) sample_ring[i] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                set_tap_count(DIR_ROWS[i].tc);
            else
                send_beat(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].coef,
                          DIR_ROWS[i].smp, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_tap_count(PHASE_TAPS[p]);
            calm = (p == CALM_PHASE);
            n = taps_in_use();
            // coefficients in use must be loaded before any sample beat
            for (int s = 0; s < n; s++)
                if (!coef_known[s])
                    send_beat(OP_LOAD, IDX_W'(s), rand_word(), rand_word(), 1'b0, '0);
            cnt = 0;
            while (cnt < PHASE_BEATS[p]) begin
                r = $urandom_range(99);
                if (r < 55) op = OP_FILTER;
                else if (r < 80) op = OP_LOAD;
                else if (r < 88) op = OP_RESTART;
                else op = OP_UNUSED;
                idx = (op == OP_LOAD && r[0]) ? IDX_W'($urandom_range(n - 1))
                                              : IDX_W'($urandom);
                send_beat(op, idx, rand_word(), rand_word(), 1'b0, '0);
                cnt++;
            end
            calm = 1'b0;
        end

        in_ch.valid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge i_clk);
        repeat (MAX_TAPS + 8) @(posedge i_clk);

        $display("checked %0d filtered results; %0d coefficient loads, %0d restarts",
                 n_checked, n_loads, n_restarts);
        $display("%0d ignored beats, %0d tap count writes, %0d mismatches",
                 n_ignored, n_cfg, n_mismatch);
        if (n_mismatch == 0 && expected_filtered.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/nfir_pkg.sv
rtl/nfir_if.sv
rtl/nfir_mem.sv
rtl/nfir_mac.sv
rtl/nfir_ctrl.sv
rtl/negated_fir_filter.sv
verif/negated_fir_filter_tb.sv
